>>> src/infix_to_postfix_converter_defines.svh
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_defines
// assertion macros used by the checker
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define ITP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// shared types, character codes and operator helpers of the converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itp_pkg;

  // operator codes as held on the stack
  typedef enum logic [2:0] {
    OP_LPAREN = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_MOD    = 3'd5,
    OP_POW    = 3'd6
  } op_code_t;

  // command kinds passed from front to back
  typedef enum logic [4:0] {
    K_ALNUM  = 5'b00001,
    K_LPAREN = 5'b00010,
    K_RPAREN = 5'b00100,
    K_OPER   = 5'b01000,
    K_END    = 5'b10000
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  ch;
    op_code_t    op;
  } cmd_t;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_MOD    = 8'h25;
  localparam logic [7:0] CH_POW    = 8'h5E;
  localparam logic [7:0] CH_NUL    = 8'h00;

  function automatic logic [7:0] op_char(op_code_t op);
    logic [7:0] c;
    unique case (op)
      OP_LPAREN: c = CH_LPAREN;
      OP_ADD:    c = CH_ADD;
      OP_SUB:    c = CH_SUB;
      OP_MUL:    c = CH_MUL;
      OP_DIV:    c = CH_DIV;
      OP_MOD:    c = CH_MOD;
      OP_POW:    c = CH_POW;
      default:   c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] op_prec(op_code_t op);
    logic [1:0] p;
    unique case (op)
      OP_ADD, OP_SUB:         p = 2'd1;
      OP_MUL, OP_DIV, OP_MOD: p = 2'd2;
      OP_POW:                 p = 2'd3;
      default:                p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

>>> src/itp_front.sv
// ----------------------------------------------------------------------------
// itp_front
// takes input words, classifies them and queues commands for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itp_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_char,
  input  logic           end_of_expr,
  input  logic           q_full,
  output logic           q_push,
  output itp_pkg::cmd_t  q_cmd
);

  logic keep;

  always_comb begin
    q_cmd.ch   = in_char;
    q_cmd.op   = itp_pkg::OP_LPAREN;
    q_cmd.kind = itp_pkg::K_END;
    keep       = 1'b1;
    priority if (end_of_expr) begin
      q_cmd.kind = itp_pkg::K_END;
    end else if (itp_pkg::is_alnum(in_char)) begin
      q_cmd.kind = itp_pkg::K_ALNUM;
    end else if (in_char == itp_pkg::CH_RPAREN) begin
      q_cmd.kind = itp_pkg::K_RPAREN;
    end else if (in_char == itp_pkg::CH_LPAREN) begin
      q_cmd.kind = itp_pkg::K_LPAREN;
    end else begin
      q_cmd.kind = itp_pkg::K_OPER;
      unique case (in_char)
        itp_pkg::CH_ADD: q_cmd.op = itp_pkg::OP_ADD;
        itp_pkg::CH_SUB: q_cmd.op = itp_pkg::OP_SUB;
        itp_pkg::CH_MUL: q_cmd.op = itp_pkg::OP_MUL;
        itp_pkg::CH_DIV: q_cmd.op = itp_pkg::OP_DIV;
        itp_pkg::CH_MOD: q_cmd.op = itp_pkg::OP_MOD;
        itp_pkg::CH_POW: q_cmd.op = itp_pkg::OP_POW;
        default:         keep = 1'b0;   // anything else is dropped
      endcase
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

>>> src/itp_queue.sv
// ----------------------------------------------------------------------------
// itp_queue
// short command queue between front and back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  itp_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output itp_pkg::cmd_t  pop_cmd
);

  localparam int unsigned PW = (itp_pkg::QUEUE_DEPTH > 1) ? $clog2(itp_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(itp_pkg::QUEUE_DEPTH + 1);

  itp_pkg::cmd_t   entries [itp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(itp_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(itp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(itp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> src/itp_back.sv
// ----------------------------------------------------------------------------
// itp_back
// operator stack engine: one push, pop or emit per cycle unless the output stalls, with output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itp_back #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  itp_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_char,
  output logic           run_last,
  output logic           expr_done,
  output logic           overflow_seen
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  // top entry in a register, entries below it in memory
  itp_pkg::op_code_t mem [STACK_DEPTH];
  itp_pkg::op_code_t top;
  itp_pkg::op_code_t top_next;
  itp_pkg::op_code_t rd_q;       // entry just below top, prefetched

  itp_pkg::cmd_t   cur;
  logic            cur_valid;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            ovf;

  logic            out_space;
  logic            nonempty;
  logic            has_one;
  logic            full;
  logic            do_pop;
  logic            do_push;
  logic            emit;
  logic [7:0]      emit_char;
  logic            emit_last;
  logic            emit_done;
  logic            clear;
  logic            done;
  logic            wr_en;
  logic            rd_en;
  logic [CW-1:0]   wr_sub;
  logic [CW-1:0]   rd_sub;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  logic [1:0]      top_prec;
  logic [1:0]      nxt_prec;
  logic [1:0]      cur_prec;

  assign out_space = !out_valid || out_ready;
  assign nonempty  = (count != '0);
  assign has_one   = (count == CW'(1));
  assign full      = (count == CW'(STACK_DEPTH));
  assign top_prec  = itp_pkg::op_prec(top);
  assign nxt_prec  = itp_pkg::op_prec(rd_q);
  assign cur_prec  = itp_pkg::op_prec(cur.op);

  always_comb begin
    do_pop    = 1'b0;
    do_push   = 1'b0;
    emit      = 1'b0;
    emit_char = itp_pkg::op_char(top);
    emit_last = 1'b0;
    emit_done = 1'b0;
    clear     = 1'b0;
    done      = 1'b0;
    if (cur_valid) begin
      unique case (cur.kind)
        itp_pkg::K_ALNUM: begin
          if (out_space) begin
            emit      = 1'b1;
            emit_char = cur.ch;
            emit_last = 1'b1;
            done      = 1'b1;
          end
        end
        itp_pkg::K_LPAREN: begin
          do_push = 1'b1;
          done    = 1'b1;
        end
        itp_pkg::K_RPAREN: begin
          if (!nonempty) begin
            done = 1'b1;
          end else if (top == itp_pkg::OP_LPAREN) begin
            do_pop = 1'b1;
            done   = 1'b1;
          end else if (out_space) begin
            emit      = 1'b1;
            do_pop    = 1'b1;
            emit_last = has_one || (rd_q == itp_pkg::OP_LPAREN);
            done      = has_one;
          end
        end
        itp_pkg::K_OPER: begin
          if ((cur.op != itp_pkg::OP_POW) && nonempty && (top_prec >= cur_prec)) begin
            if (out_space) begin
              emit      = 1'b1;
              do_pop    = 1'b1;
              emit_last = has_one || (nxt_prec < cur_prec);
            end
          end else begin
            do_push = 1'b1;
            done    = 1'b1;
          end
        end
        itp_pkg::K_END: begin
          if (nonempty) begin
            if (out_space) begin
              emit   = 1'b1;
              do_pop = 1'b1;
            end
          end else if (out_space) begin
            emit      = 1'b1;
            emit_char = itp_pkg::CH_NUL;
            emit_last = 1'b1;
            emit_done = 1'b1;
            clear     = 1'b1;
            done      = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign cmd_pop = cmd_valid && (!cur_valid || done);

  always_comb begin
    count_next = count;
    top_next   = top;
    if (clear) begin
      count_next = '0;
    end else if (do_pop) begin
      count_next = count - CW'(1);
      top_next   = rd_q;
    end else if (do_push && !full) begin
      count_next = count + CW'(1);
      top_next   = cur.op;
    end
  end

  assign wr_en   = do_push && !full && nonempty;
  assign wr_sub  = count - CW'(1);
  assign wr_addr = wr_sub[AW-1:0];
  assign rd_en   = (count_next >= CW'(2));
  assign rd_sub  = count_next - CW'(2);
  assign rd_addr = rd_sub[AW-1:0];

  // stack memory, write-first on the shared address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_q <= top;
    end else if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (emit) begin
      out_char      <= emit_char;
      run_last      <= emit_last;
      expr_done     <= emit_done;
      overflow_seen <= emit_done && ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd_pop) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
      if (clear) begin
        ovf <= 1'b0;
      end else if (do_push && full) begin
        ovf <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/infix_to_postfix_converter.sv
// first result word passes the queue entry, the command register and the output register, back end idle
// the back end loads the next command as the current one finishes; each popped operator adds a step
// a ')' that finds no '(' below its operators finishes on its last pop
// an end word pops and emits each stacked entry, then emits the end marker
// the stack engine does one push, pop or emit per cycle, held while the output stalls, and sets the rate
// reset: synchronous, active high; clears queue, stack count, overflow flag, valids
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// shunting-yard conversion of an infix character stream into postfix form
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        end_of_expr,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        run_last,
  output logic        expr_done,
  output logic        overflow_seen
);

  // front to queue
  logic           q_full;
  logic           q_push;
  itp_pkg::cmd_t  q_in;
  // queue to back end
  logic           q_pop;
  logic           q_not_empty;
  itp_pkg::cmd_t  q_out;

  // front end: classify each word; ignored characters are taken and dropped here
  itp_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char     (in_char),
    .end_of_expr (end_of_expr),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_in)
  );

  // two-entry command queue lets the front keep taking words while the stack works
  itp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (q_out)
  );

  // back end: operator stack (top in a register, rest in memory) and output register
  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (q_not_empty),
    .cmd           (q_out),
    .cmd_pop       (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .run_last      (run_last),
    .expr_done     (expr_done),
    .overflow_seen (overflow_seen)
  );

endmodule

>>> src/itp_checker.sv
// ----------------------------------------------------------------------------
// itp_checker
// port-level checks on the converter's result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_defines.svh"

module itp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_char,
  input logic        run_last,
  input logic        expr_done,
  input logic        overflow_seen
);

  logic        out_stall;
  logic [10:0] out_word;

  assign out_stall = out_valid && !out_ready;
  assign out_word  = {out_char, run_last, expr_done, overflow_seen};

  // a stalled result word holds
  `ITP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled word changed")

  // the end marker always closes its item's run
  `ITP_ASSERT_NOW(a_done_last, out_valid && expr_done, run_last, "end marker without run_last")

  // the end marker carries a null character
  `ITP_ASSERT_NOW(a_done_nul, out_valid && expr_done, out_char == 8'h00, "end marker char not zero")

  // overflow is reported only on the end marker
  `ITP_ASSERT_NOW(a_ovf_marker, out_valid && overflow_seen, expr_done, "overflow off end marker")

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);
